@@ src/set_assoc_lru_cache_model_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SALC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define SALC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SALC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ src/salc_pkg.sv @@
// ---------------------------------------------------------------------------
// salc_pkg
// Shared constants and types of the LRU cache model.
// ---------------------------------------------------------------------------
package salc_pkg;
   localparam int MAX_SET_BITS_DEF = 10;
   localparam int MAX_WAYS_DEF     = 8;
   localparam int ADDR_WIDTH_DEF   = 64;
   localparam int CNT_W            = 32;
   localparam int CSR_AW           = 4;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_STORE  = 2'd1;
   localparam logic [1:0] FUNC_MODIFY = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   localparam logic [CSR_AW-1:0] REG_SET_BITS   = 4'h0;
   localparam logic [CSR_AW-1:0] REG_BLOCK_BITS = 4'h4;
   localparam logic [CSR_AW-1:0] REG_WAYS       = 4'h8;

   typedef struct packed {
      logic hit;
      logic miss;
      logic eviction;
   } flags_type;
endpackage

@@ src/salc_ram.sv @@
// ---------------------------------------------------------------------------
// salc_ram
// Generic single-port-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ src/salc_lookup.sv @@
// ---------------------------------------------------------------------------
// salc_lookup
// Way compare and victim choice over one set read from memory.
// ---------------------------------------------------------------------------
module salc_lookup #(
   parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
   parameter int TAG_W    = 62
) (
   input  logic [MAX_WAYS-1:0]                      valid,
   input  logic [MAX_WAYS-1:0][TAG_W-1:0]           tags,
   input  logic [MAX_WAYS-1:0][$clog2(MAX_WAYS+1)-1:0] ranks,
   input  logic [$clog2(MAX_WAYS+1)-1:0]            nways,
   input  logic [TAG_W-1:0]                         tag,
   output salc_pkg::flags_type                      flags,
   output logic [$clog2(MAX_WAYS+1)-1:0]            pick
);
   localparam int RW = $clog2(MAX_WAYS + 1);
   logic          found_h, found_i;
   logic [RW-1:0] hit_w, hit_r, inv_w, lru_w, lru_r;

   always_comb begin
      found_h = 1'b0;
      found_i = 1'b0;
      hit_w = '0;
      hit_r = '0;
      inv_w = '0;
      lru_w = '0;
      lru_r = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (RW'(w) < nways) begin
            if (valid[w] && tags[w] == tag && (!found_h || ranks[w] < hit_r)) begin
               found_h = 1'b1;
               hit_w = RW'(w);
               hit_r = ranks[w];
            end
            if (!valid[w] && !found_i) begin
               found_i = 1'b1;
               inv_w = RW'(w);
            end
            if (w == 0 || ranks[w] > lru_r) begin
               lru_w = RW'(w);
               lru_r = ranks[w];
            end
         end
      end
      flags.hit = found_h;
      flags.miss = !found_h;
      flags.eviction = !found_h && !found_i;
      pick = found_h ? hit_w : (found_i ? inv_w : lru_w);
   end
endmodule

@@ src/set_assoc_lru_cache_model_top.sv @@
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// Tag-only set-associative cache model with true LRU replacement.
// ---------------------------------------------------------------------------
// Channel | Direction | Payload
// req     | in        | tuser = func[1:0], tdata = address
// rsp     | out       | tuser = {eviction,miss,hit}, tlast = last, tdata = totals
// csr     | in        | APB: set_bits, block_bits, ways
//
// Each access reads the whole set (tags, valid bits, ranks as one wide word),
// compares and writes it back in the next cycle, then presents the
// response. A load or store steps through read, update, response and idle
// between request transfers; a modify runs its two accesses back to back.
// Reset: a clearing pass writes every set (valid zero, ranks in way order)
// before the first request is taken.
// A stalled response holds the next access; one item is in flight.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_top_assert.svh"
module set_assoc_lru_cache_model_top #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
   parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // address[63:0]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // hit_total, miss_total, eviction_total
   output logic [2:0]  rsp_tuser,   // hit, miss, eviction
   output logic        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [salc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   localparam int RW    = $clog2(MAX_WAYS + 1);
   localparam int SETS  = 1 << MAX_SET_BITS;
   localparam int SW    = MAX_SET_BITS;
   localparam int TAG_W = ADDR_WIDTH - 2;
   localparam int LW    = 1 + TAG_W + RW;
   localparam int WORD  = MAX_WAYS * LW;
   localparam int CW    = salc_pkg::CNT_W;

   typedef enum logic [2:0] {CLEAR, IDLE, READ, UPDATE, RESP} state_type;

   state_type          state_ff, state_in;
   logic [3:0]         set_bits_ff, block_bits_ff, ways_ff;
   logic [SW:0]        clr_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic               two_ff, last_ff;
   logic [CW-1:0]      hits_ff, miss_ff, evict_ff;
   salc_pkg::flags_type flags_ff, flags;
   logic               rsp_valid_ff;

   logic [SW-1:0]      set_idx, ram_waddr;
   logic [TAG_W-1:0]   tag;
   logic [WORD-1:0]    rd_word, wr_word;
   logic               ram_we;
   logic [MAX_WAYS-1:0] v_r;
   logic [MAX_WAYS-1:0][TAG_W-1:0] t_r;
   logic [MAX_WAYS-1:0][RW-1:0]    r_r;
   logic [RW-1:0]      nways, pick, old_rank;
   logic [3:0]         sb, bb;

   // Clamp configuration at use.
   always_comb begin
      sb = (set_bits_ff == 4'd0) ? 4'd1 :
           ({28'd0, set_bits_ff} > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_ff;
      bb = (block_bits_ff == 4'd0) ? 4'd1 : block_bits_ff;
      nways = (ways_ff == 4'd0) ? RW'(1) :
              ({28'd0, ways_ff} > MAX_WAYS) ? RW'(MAX_WAYS) : RW'(ways_ff);
   end

   logic [ADDR_WIDTH-1:0] sh_addr;
   logic [ADDR_WIDTH-1:0] set_mask;
   always_comb begin
      sh_addr  = addr_ff >> bb;
      set_mask = (ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1);
      set_idx  = SW'(sh_addr & set_mask);
      tag      = TAG_W'(sh_addr >> sb);
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         v_r[w] = rd_word[w*LW + LW - 1];
         t_r[w] = rd_word[w*LW + RW +: TAG_W];
         r_r[w] = rd_word[w*LW +: RW];
      end
   end

   salc_lookup #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W)) u_lookup (
      .valid(v_r), .tags(t_r), .ranks(r_r), .nways(nways), .tag(tag),
      .flags(flags), .pick(pick)
   );

   // Rank of the picked way before promotion.
   always_comb begin
      old_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (RW'(w) == pick) old_rank = r_r[w];
      end
   end

   // Write-back word: fill on miss, promote picked way to rank 0; CLEAR resets.
   always_comb begin
      wr_word = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (state_ff == CLEAR) begin
            wr_word[w*LW +: LW] = {1'b0, {TAG_W{1'b0}}, RW'(w)};
         end else begin
            wr_word[w*LW + LW - 1] = (RW'(w) == pick) ? 1'b1 : v_r[w];
            wr_word[w*LW + RW +: TAG_W] =
               (RW'(w) == pick && flags.miss) ? tag : t_r[w];
            wr_word[w*LW +: RW] = (RW'(w) == pick) ? RW'(0) :
               (r_r[w] < old_rank) ? r_r[w] + RW'(1) : r_r[w];
         end
      end
   end

   assign ram_we    = (state_ff == CLEAR) || (state_ff == UPDATE);
   assign ram_waddr = (state_ff == CLEAR) ? clr_ff[SW-1:0] : set_idx;

   salc_ram #(.WIDTH(WORD), .DEPTH(SETS)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(wr_word),
      .raddr(set_idx), .rdata(rd_word)
   );

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {evict_ff, miss_ff, hits_ff};
   assign rsp_tuser  = {flags_ff.eviction, flags_ff.miss, flags_ff.hit};
   assign rsp_tlast  = last_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr)
         salc_pkg::REG_SET_BITS:   csr_prdata = {28'd0, set_bits_ff};
         salc_pkg::REG_BLOCK_BITS: csr_prdata = {28'd0, block_bits_ff};
         salc_pkg::REG_WAYS:       csr_prdata = {28'd0, ways_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
      sat_inc = (en && v != '1) ? v + CW'(1) : v;
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CLEAR:  if (clr_ff == (SW+1)'(SETS - 1)) state_in = IDLE;
         IDLE:   if (req_tvalid) state_in = READ;
         READ:   state_in = UPDATE;
         UPDATE: state_in = RESP;
         RESP:   if (rsp_tready) state_in = two_ff ? READ : IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLEAR;
         clr_ff        <= '0;
         set_bits_ff   <= 4'd1;
         block_bits_ff <= 4'd1;
         ways_ff       <= 4'd1;
         hits_ff       <= '0;
         miss_ff       <= '0;
         evict_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         two_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == CLEAR) clr_ff <= clr_ff + (SW+1)'(1);
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_paddr)
               salc_pkg::REG_SET_BITS:   set_bits_ff   <= csr_pwdata[3:0];
               salc_pkg::REG_BLOCK_BITS: block_bits_ff <= csr_pwdata[3:0];
               salc_pkg::REG_WAYS:       ways_ff       <= csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (state_ff == IDLE && req_tvalid) begin
            addr_ff <= req_tdata[ADDR_WIDTH-1:0];
            two_ff  <= (req_tuser == salc_pkg::FUNC_MODIFY);
            last_ff <= (req_tuser != salc_pkg::FUNC_MODIFY);
         end
         if (state_ff == UPDATE) begin
            // Count and present the result of this access.
            flags_ff     <= flags;
            hits_ff      <= sat_inc(hits_ff, flags.hit);
            miss_ff      <= sat_inc(miss_ff, flags.miss);
            evict_ff     <= sat_inc(evict_ff, flags.eviction);
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == RESP && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
            if (two_ff) begin
               two_ff  <= 1'b0;
               last_ff <= 1'b1;
            end
         end
      end
   end

   `SALC_ASSERT_IMPL(a_one_flag, clock, reset, (!rsp_tvalid || (rsp_tuser[0] ^ rsp_tuser[1])), "hit/miss")
   `SALC_ASSERT_IMPL(a_evict_miss, clock, reset, (!rsp_tvalid || !rsp_tuser[2] || rsp_tuser[1]), "evict")
   `SALC_ASSERT_NEXT(a_no_take, clock, reset, (rsp_tvalid), (!req_tready || !rsp_tvalid), "overlap")
endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// Testbench for the set-associative LRU cache model
// Streams loads, stores, modifies and spare codes through the block under several
// register settings. A local cache predictor works out the flags and totals
// for each transfer, and the response stream is checked against it in order.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSETS      = 1 << salc_pkg::MAX_SET_BITS_DEF;
   localparam int NWAYS      = salc_pkg::MAX_WAYS_DEF;
   localparam int SETTLE     = 12;
   localparam int CYCLE_CAP  = 400000;
   localparam int LONG_HOLD  = 300;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] address;
   } access_item;

   typedef struct {
      logic        hit;
      logic        miss;
      logic        eviction;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
      logic        last;
   } lookup_result;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // address[63:0]
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;        // hit_total, miss_total, eviction_total
   logic [2:0]  rsp_tuser;        // hit, miss, eviction
   logic        rsp_tlast;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [salc_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   set_assoc_lru_cache_model_top uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // predictor state: one copy of the cache directory and the registers
   logic [63:0] line_tag   [NSETS][NWAYS];
   logic        line_valid [NSETS][NWAYS];
   logic [2:0]  line_rank  [NSETS][NWAYS];
   logic [31:0] hits_cnt, misses_cnt, evicts_cnt;
   logic [3:0]  cfg_set_bits, cfg_block_bits, cfg_ways;

   access_item   pending[$];
   lookup_result awaited[$];
   int errors = 0;
   int n_results = 0;
   int n_hits = 0, n_evicts = 0;
   int cycles = 0;
   bit long_hold_req = 0;

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   // run one lookup through the predicted directory and queue its result
   function automatic void lookup(logic [63:0] address, logic is_last);
      int sb, bb, nw, set_idx, pick, pick_rank, old_rank;
      logic [63:0] tag;
      lookup_result r;
      sb = (cfg_set_bits < 1) ? 1 : (cfg_set_bits > salc_pkg::MAX_SET_BITS_DEF) ?
           salc_pkg::MAX_SET_BITS_DEF : cfg_set_bits;
      bb = (cfg_block_bits < 1) ? 1 : cfg_block_bits;
      nw = (cfg_ways < 1) ? 1 : (cfg_ways > NWAYS) ? NWAYS : cfg_ways;
      set_idx = int'((address >> bb) & ((64'd1 << sb) - 1));
      tag = (address >> bb) >> sb;
      pick = -1;
      pick_rank = 0;
      r = '{default: 0};
      // the most recent matching way wins when stale duplicates exist
      for (int w = 0; w < nw; w++)
         if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag &&
             (pick < 0 || line_rank[set_idx][w] < pick_rank)) begin
            pick = w;
            pick_rank = line_rank[set_idx][w];
         end
      if (pick >= 0) begin
         r.hit = 1;
      end else begin
         r.miss = 1;
         for (int w = 0; w < nw && pick < 0; w++)
            if (!line_valid[set_idx][w]) pick = w;
         if (pick < 0) begin
            r.eviction = 1;
            for (int w = 0; w < nw; w++)
               if (pick < 0 || line_rank[set_idx][w] > pick_rank) begin
                  pick = w;
                  pick_rank = line_rank[set_idx][w];
               end
         end
         line_valid[set_idx][pick] = 1;
         line_tag[set_idx][pick] = tag;
      end
      old_rank = line_rank[set_idx][pick];
      for (int w = 0; w < NWAYS; w++)
         if (line_rank[set_idx][w] < old_rank) line_rank[set_idx][w]++;
      line_rank[set_idx][pick] = 0;
      if (r.hit) hits_cnt = sat_inc(hits_cnt);
      if (r.miss) misses_cnt = sat_inc(misses_cnt);
      if (r.eviction) evicts_cnt = sat_inc(evicts_cnt);
      r.hit_total = hits_cnt;
      r.miss_total = misses_cnt;
      r.eviction_total = evicts_cnt;
      r.last = is_last;
      awaited.push_back(r);
   endfunction

   // sender: bursts of random length, random gaps, hold until accepted
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      bit offer, took;
      offer = 0;
      took = req_tvalid && req_tready;
      if (took) begin
         if (req_tuser == salc_pkg::FUNC_MODIFY) begin
            lookup(req_tdata, 0);
            lookup(req_tdata, 1);
         end else begin
            lookup(req_tdata, 1);
         end
         void'(pending.pop_front());
      end
      if (!reset && pending.size() > 0) begin
         if (req_tvalid && !took) begin
            offer = 1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else begin
            offer = 1;
            if (burst_left == 0) burst_left = $urandom_range(1, 16);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end
      end
      req_tvalid <= offer;
      if (offer) begin
         req_tdata <= pending[0].address;
         req_tuser <= pending[0].func;
      end
   end

   // receiver: random stall mask, reseeded from a window counter, plus one long hold
   logic [31:0] stall_mask = '1;
   int hold_left = 0;
   always @(posedge clock) begin
      lookup_result e;
      bit ready;
      if (rsp_tvalid && rsp_tready) begin
         n_results++;
         if (awaited.size() == 0) begin
            $display("%t: unexpected result tuser=%h tlast=%b tdata=%h", $realtime,
                     rsp_tuser, rsp_tlast, rsp_tdata);
            errors++;
         end else begin
            e = awaited.pop_front();
            if ({e.eviction, e.miss, e.hit} !== rsp_tuser) begin
               $display("%t: flags expected %b actual %b", $realtime,
                        {e.eviction, e.miss, e.hit}, rsp_tuser);
               errors++;
            end
            if (e.last !== rsp_tlast) begin
               $display("%t: last expected %b actual %b", $realtime,
                        e.last, rsp_tlast);
               errors++;
            end
            if (e.hit_total !== rsp_tdata[31:0]) begin
               $display("%t: hit_total expected %0d actual %0d", $realtime,
                        e.hit_total, rsp_tdata[31:0]);
               errors++;
            end
            if (e.miss_total !== rsp_tdata[63:32]) begin
               $display("%t: miss_total expected %0d actual %0d", $realtime,
                        e.miss_total, rsp_tdata[63:32]);
               errors++;
            end
            if (e.eviction_total !== rsp_tdata[95:64]) begin
               $display("%t: eviction_total expected %0d actual %0d", $realtime,
                        e.eviction_total, rsp_tdata[95:64]);
               errors++;
            end
            n_hits += e.hit;
            n_evicts += e.eviction;
         end
      end
      if (cycles % 32 == 0)
         case ($urandom_range(0, 3))
            0, 1: stall_mask <= '1;
            2: stall_mask <= $urandom | $urandom;
            default: stall_mask <= $urandom & $urandom;
         endcase
      if (hold_left > 0) begin
         hold_left--;
         ready = 0;
      end else if (long_hold_req) begin
         long_hold_req = 0;
         hold_left = LONG_HOLD;
         ready = 0;
      end else begin
         ready = stall_mask[cycles % 32];
      end
      rsp_tready <= !reset && ready;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [salc_pkg::CSR_AW-1:0] addr, logic [3:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= 32'({$urandom, 4'h0}) | {28'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      // the block keeps only the low four bits
      case (addr)
         salc_pkg::REG_SET_BITS: cfg_set_bits = value;
         salc_pkg::REG_BLOCK_BITS: cfg_block_bits = value;
         default: cfg_ways = value;
      endcase
   endtask

   task automatic configure(logic [3:0] sb, logic [3:0] bb, logic [3:0] nw);
      csr_write(salc_pkg::REG_SET_BITS, sb);
      csr_write(salc_pkg::REG_BLOCK_BITS, bb);
      csr_write(salc_pkg::REG_WAYS, nw);
   endtask

   // wait until every access is sent and every result is back, then let the block settle
   task automatic drain();
      while (pending.size() > 0 || awaited.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add(logic [1:0] func, logic [63:0] address);
      access_item it;
      it.func = func;
      it.address = address;
      pending.push_back(it);
   endtask

   // well-formed traffic: mostly a small pool of hot lines, some noise
   task automatic add_random(int count);
      logic [63:0] hot[16];
      foreach (hot[i]) hot[i] = {$urandom, $urandom} & ({$urandom, $urandom} |
                                 ((64'd1 << $urandom_range(4, 24)) - 1));
      repeat (count) begin
         logic [63:0] a;
         logic [1:0]  f;
         f = ($urandom_range(0, 9) == 0) ? salc_pkg::FUNC_SPARE :
             2'($urandom_range(0, 2));
         if ($urandom_range(0, 9) < 7) a = hot[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 3));
         else a = {$urandom, $urandom};
         add(f, a);
      end
   endtask

   initial begin
      logic [3:0] cfgs[7][3];
      cfgs = '{'{4'd0, 4'd0, 4'd0}, '{4'd15, 4'd15, 4'd15}, '{4'd1, 4'd1, 4'd8},
               '{4'd2, 4'd4, 4'd4}, '{4'd10, 4'd12, 4'd8}, '{4'd3, 4'd2, 4'd2},
               '{4'd1, 4'd3, 4'd3}};
      for (int s = 0; s < NSETS; s++)
         for (int w = 0; w < NWAYS; w++) begin
            line_tag[s][w] = '0;
            line_valid[s][w] = 0;
            line_rank[s][w] = 3'(w);
         end
      hits_cnt = 0;
      misses_cnt = 0;
      evicts_cnt = 0;
      cfg_set_bits = 1;
      cfg_block_bits = 1;
      cfg_ways = 1;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: default registers, one way, address extremes, every kind
      add(salc_pkg::FUNC_LOAD, 64'd0);
      add(salc_pkg::FUNC_LOAD, '1);
      add(salc_pkg::FUNC_STORE, 64'd0);
      add(salc_pkg::FUNC_MODIFY, 64'd4);
      add(salc_pkg::FUNC_SPARE, 64'd2);
      add(salc_pkg::FUNC_MODIFY, '1);
      add(salc_pkg::FUNC_STORE, 64'h8000_0000_0000_0000);
      drain();
      // two ways, fill a set and force LRU victims
      configure(4'd1, 4'd1, 4'd2);
      add(salc_pkg::FUNC_LOAD, 64'h00);
      add(salc_pkg::FUNC_LOAD, 64'h04);
      add(salc_pkg::FUNC_LOAD, 64'h00);
      add(salc_pkg::FUNC_STORE, 64'h08);
      add(salc_pkg::FUNC_LOAD, 64'h04);
      add(salc_pkg::FUNC_MODIFY, 64'h0C);
      add(salc_pkg::FUNC_LOAD, 64'h00);
      drain();
      // shrink to one way: stale tags in higher ways must be ignored
      configure(4'd1, 4'd1, 4'd1);
      add(salc_pkg::FUNC_LOAD, 64'h08);
      add(salc_pkg::FUNC_LOAD, 64'h00);
      drain();
      // widen again: duplicate tags, the most recent one hits
      configure(4'd1, 4'd1, 4'd8);
      add(salc_pkg::FUNC_LOAD, 64'h00);
      add(salc_pkg::FUNC_MODIFY, 64'h08);
      drain();

      foreach (cfgs[p]) begin
         configure(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
         add_random(75);
         // hold the response side long enough to back up the input
         if (p == 2) long_hold_req = 1;
         drain();
      end

      $display("accesses checked: %0d results, %0d hits, %0d evictions",
               n_results, n_hits, n_evicts);
      $display("register settings covered include zero and all-ones values");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+src
src/salc_pkg.sv
src/salc_ram.sv
src/salc_lookup.sv
src/set_assoc_lru_cache_model_top.sv
test/tb_top.sv
